// File: sv/assert_macros.svh
// Assertion macros used by the RTL top level of the lock directory.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LDRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define LDRR_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LDRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LDRR_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: sv/ldrr_pkg.sv
// Types, constants and codes shared by the lock directory modules.
package ldrr_pkg;

  localparam int LOCK_SLOTS = 64;
  localparam int CLIENTS    = 16;
  localparam int SLOT_W     = 6;
  localparam int CLIENT_W   = 4;
  localparam int COUNT_W    = 32;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_STAT    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RETRY   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // One lock entry as stored in the directory memory.
  typedef struct packed {
    logic                held;
    logic [CLIENT_W-1:0] owner;
    logic                revoke_sent;
    logic [CLIENTS-1:0]  waiters;
  } entry_t;

  // A request beat as held during its read-modify-write.
  typedef struct packed {
    logic [1:0]          op;
    logic [SLOT_W-1:0]   slot;
    logic [CLIENT_W-1:0] client;
  } req_t;

  // Outcome of one request computed from the fetched entry.
  typedef struct packed {
    logic                we;
    logic                set_exists;
    entry_t              entry;
    logic                count_inc;
    status_t             status;
    logic                send_revoke;
    logic                send_retry;
    logic [CLIENT_W-1:0] target;
  } upd_t;

endpackage

// File: sv/ldrr_req_if.sv
// Request and result channel interfaces of the lock directory.
interface ldrr_req_if;
  import ldrr_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [SLOT_W-1:0]   lock_slot;
  logic [CLIENT_W-1:0] client;

  modport source (output valid, operation, lock_slot, client, input ready);
  modport sink   (input valid, operation, lock_slot, client, output ready);
endinterface

interface ldrr_rsp_if;
  import ldrr_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                send_revoke;
  logic                send_retry;
  logic [CLIENT_W-1:0] target_client;
  logic [COUNT_W-1:0]  acquire_count;

  modport source (output valid, status, send_revoke, send_retry, target_client,
                  acquire_count, input ready);
  modport sink   (input valid, status, send_revoke, send_retry, target_client,
                  acquire_count, output ready);
endinterface

// File: sv/ldrr_entry_ram.sv
// Lock entry memory: one write port, one read port with registered data.
module ldrr_entry_ram
  import ldrr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [LOCK_SLOTS];
  entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ldrr_update.sv
// Modify step: computes the new lock entry and the result of one request.
module ldrr_update
  import ldrr_pkg::*;
(
  input  req_t   req,
  input  logic   exists,
  input  entry_t rd_entry,
  output upd_t   upd
);

  entry_t              cur;
  entry_t              nxt;
  logic                slot_oor;
  logic                client_oor;
  logic [CLIENTS-1:0]  cl_bit;
  logic [CLIENTS-1:0]  lowest_oh;
  logic [CLIENT_W-1:0] lowest_idx;
  logic                many_waiters;

  // An entry never created reads as all zero.
  assign cur        = exists ? rd_entry : '0;
  assign slot_oor   = {1'b0, req.slot} >= (SLOT_W+1)'(LOCK_SLOTS);
  assign client_oor = {1'b0, req.client} >= (CLIENT_W+1)'(CLIENTS);
  assign cl_bit     = CLIENTS'(1) << req.client;

  // Lowest waiter: isolate the lowest set bit, then encode it.
  assign lowest_oh    = cur.waiters & (~cur.waiters + CLIENTS'(1));
  assign many_waiters = (cur.waiters & (cur.waiters - CLIENTS'(1))) != '0;

  always_comb begin
    lowest_idx = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      if (lowest_oh[i]) begin
        lowest_idx = lowest_idx | CLIENT_W'(i);
      end
    end
  end

  // Per-operation entry update and result.
  always_comb begin
    nxt             = cur;
    upd             = '0;
    upd.status      = ST_OK;
    unique case (req.op)
      OP_ACQUIRE: begin
        upd.count_inc = 1'b1;
        if (slot_oor || client_oor) begin
          upd.status = ST_RETRY;
        end else begin
          upd.we         = 1'b1;
          upd.set_exists = 1'b1;
          if (!cur.held) begin
            nxt.held        = 1'b1;
            nxt.owner       = req.client;
            nxt.waiters     = cur.waiters & ~cl_bit;
            nxt.revoke_sent = 1'b0;
            upd.status      = ST_OK;
          end else begin
            nxt.waiters = cur.waiters | cl_bit;
            if (!cur.revoke_sent) begin
              nxt.revoke_sent = 1'b1;
              upd.send_revoke = 1'b1;
              upd.target      = cur.owner;
            end
            upd.status = ST_RETRY;
          end
        end
      end
      OP_RELEASE: begin
        if (slot_oor || !exists) begin
          upd.status = ST_UNKNOWN;
        end else begin
          upd.we          = 1'b1;
          nxt.held        = 1'b0;
          nxt.owner       = '0;
          nxt.revoke_sent = 1'b0;
          if (cur.waiters != '0) begin
            upd.target      = lowest_idx;
            upd.send_retry  = 1'b1;
            upd.send_revoke = many_waiters;
          end
          upd.status = ST_OK;
        end
      end
      default: begin
        // Stat and unused codes only report the count.
        upd.status = ST_OK;
      end
    endcase
    upd.entry = nxt;
  end

endmodule

// File: sv/lock_directory_revoke_retry_unit.sv
// Top level of the lock directory with revoke and retry messaging.
//
//  channel | dir | beat payload                                          | handshake
//  in_ch   | in  | operation, lock_slot, client                          | valid/ready
//  out_ch  | out | status, send_revoke, send_retry, target_client, count | valid/ready
//
// A request is accepted in IDLE, where the accept edge issues the entry memory
// read; in EXEC the updated entry is written back and the result loaded, once the output register is empty or taken.
// One request is in flight at a time, so no read can see a stale entry.
// A held result does not block the next accept; a second result waits in
// the read-modify-write step until the output register is taken.
// Synchronous active-low reset clears the sequencer state, the entry valid bits, the count and the output valid.

`include "assert_macros.svh"

module lock_directory_revoke_retry_unit
  import ldrr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ldrr_req_if.sink   in_ch,
  ldrr_rsp_if.source out_ch
);

  state_t                state_r;
  state_t                state_nxt;
  req_t                  req_r;
  logic [LOCK_SLOTS-1:0] exists_r;
  logic [COUNT_W-1:0]    count_r;
  logic [COUNT_W-1:0]    count_nxt;
  logic                  out_valid_r;
  status_t               status_r;
  logic                  revoke_r;
  logic                  retry_r;
  logic [CLIENT_W-1:0]   target_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  accept;
  logic                  commit;
  entry_t                rd_entry;
  upd_t                  upd;

  // Entry memory.
  ldrr_entry_ram u_ram (
    .clk   (clk),
    .we    (commit && upd.we),
    .waddr (req_r.slot),
    .wdata (upd.entry),
    .re    (accept),
    .raddr (in_ch.lock_slot),
    .rdata (rd_entry)
  );

  // Entry update logic.
  ldrr_update u_update (
    .req      (req_r),
    .exists   (exists_r[req_r.slot]),
    .rd_entry (rd_entry),
    .upd      (upd)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, accept and commit.
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign count_nxt = count_r + COUNT_W'(upd.count_inc);

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op     <= in_ch.operation;
      req_r.slot   <= in_ch.lock_slot;
      req_r.client <= in_ch.client;
    end
  end

  // Entry valid bits and acquire count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exists_r <= '0;
      count_r  <= '0;
    end else if (commit) begin
      count_r <= count_nxt;
      if (upd.set_exists) begin
        exists_r[req_r.slot] <= 1'b1;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      status_r    <= upd.status;
      revoke_r    <= upd.send_revoke;
      retry_r     <= upd.send_retry;
      target_r    <= upd.target;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.send_revoke   = revoke_r;
  assign out_ch.send_retry    = retry_r;
  assign out_ch.target_client = target_r;
  assign out_ch.acquire_count = out_count_r;

  // An accepted beat always moves to the read-modify-write step.
  `LDRR_ASSERT(a_accept_exec, clk, rst_n, accept |=> (state_r == S_EXEC && !in_ch.ready), "accepted request did not enter the update step")
  // A committed request always leaves a result in the output register.
  `LDRR_ASSERT(a_commit_out, clk, rst_n, commit |=> out_valid_r, "committed request left no result")
  // A retry message only follows a successful release.
  `LDRR_NEVER(a_retry_status, clk, rst_n, out_valid_r && retry_r && status_r != ST_OK, "retry sent with a non-OK status")
  // A release of an unknown lock sends no message.
  `LDRR_NEVER(a_unknown_quiet, clk, rst_n, out_valid_r && status_r == ST_UNKNOWN && (revoke_r || retry_r), "message sent for an unknown lock")

endmodule

// File: verif/lock_directory_revoke_retry_unit_tb.sv
// Self-checking testbench for the lock directory with revoke and retry messaging.
module lock_directory_revoke_retry_unit_tb;
  import ldrr_pkg::*;

  // Operation code with no defined meaning; the directory treats it as a stat query.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_REQUESTS = 1000;

  // One result beat, laid out in the order of the result channel fields.
  typedef struct packed {
    logic [1:0]          status;
    logic                send_revoke;
    logic                send_retry;
    logic [CLIENT_W-1:0] target_client;
    logic [COUNT_W-1:0]  acquire_count;
  } lock_response_t;

  // Mirror of the lock directory plus the queue of responses still owed.
  class lock_dir_scoreboard;
    bit                  slot_known [LOCK_SLOTS];
    bit                  slot_held  [LOCK_SLOTS];
    logic [CLIENT_W-1:0] slot_owner [LOCK_SLOTS];
    bit                  revoke_out [LOCK_SLOTS];
    logic [CLIENTS-1:0]  wait_set   [LOCK_SLOTS];
    logic [COUNT_W-1:0]  acquire_total;
    lock_response_t      pending_responses [$];
    int                  error_count;

    function new();
      for (int s = 0; s < LOCK_SLOTS; s++) begin
        slot_known[s] = 0;
        slot_held[s]  = 0;
        slot_owner[s] = '0;
        revoke_out[s] = 0;
        wait_set[s]   = '0;
      end
      acquire_total = '0;
      error_count   = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the response it earns.
    function void predict_request(logic [1:0] op, logic [SLOT_W-1:0] slot,
                                  logic [CLIENT_W-1:0] cl);
      lock_response_t rsp;
      bit found;
      rsp = '0;
      rsp.status = ST_OK;
      found = 0;
      if (op == OP_ACQUIRE) begin
        acquire_total = acquire_total + 1'b1;
        if (slot >= LOCK_SLOTS || cl >= CLIENTS) begin
          rsp.status = ST_RETRY;
        end else begin
          // First touch of a slot creates a clean entry.
          if (!slot_known[slot]) begin
            slot_known[slot] = 1;
            slot_held[slot]  = 0;
            slot_owner[slot] = '0;
            revoke_out[slot] = 0;
            wait_set[slot]   = '0;
          end
          if (!slot_held[slot]) begin
            slot_held[slot]    = 1;
            slot_owner[slot]   = cl;
            wait_set[slot][cl] = 1'b0;
            revoke_out[slot]   = 0;
          end else begin
            // Contended: queue the client and revoke the owner only once.
            wait_set[slot][cl] = 1'b1;
            if (!revoke_out[slot]) begin
              revoke_out[slot]  = 1;
              rsp.send_revoke   = 1'b1;
              rsp.target_client = slot_owner[slot];
            end
            rsp.status = ST_RETRY;
          end
        end
      end else if (op == OP_RELEASE) begin
        if (slot >= LOCK_SLOTS || !slot_known[slot]) begin
          rsp.status = ST_UNKNOWN;
        end else begin
          slot_held[slot]  = 0;
          slot_owner[slot] = '0;
          revoke_out[slot] = 0;
          // The lowest-numbered waiter gets the retry; more waiters add a revoke.
          if (wait_set[slot] != '0) begin
            for (int c = 0; c < CLIENTS; c++) begin
              if (!found && wait_set[slot][c]) begin
                found = 1;
                rsp.target_client = c[CLIENT_W-1:0];
              end
            end
            rsp.send_retry = 1'b1;
            if ($countones(wait_set[slot]) > 1) rsp.send_revoke = 1'b1;
          end
        end
      end
      rsp.acquire_count = acquire_total;
      pending_responses.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want,
                                logic [COUNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    // Match one result beat against the oldest owed response.
    function void check_response(lock_response_t got);
      lock_response_t want;
      if (pending_responses.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
        return;
      end
      want = pending_responses.pop_front();
      compare_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
      compare_field("send_revoke", COUNT_W'(want.send_revoke), COUNT_W'(got.send_revoke));
      compare_field("send_retry", COUNT_W'(want.send_retry), COUNT_W'(got.send_retry));
      compare_field("target_client", COUNT_W'(want.target_client),
                    COUNT_W'(got.target_client));
      compare_field("acquire_count", want.acquire_count, got.acquire_count);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   receiver_idle_pct;
  int   quiet_cycles;
  lock_dir_scoreboard book;

  ldrr_req_if in_ch ();
  ldrr_rsp_if out_ch ();

  lock_directory_revoke_retry_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result-side backpressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Every accepted result beat is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      book.check_response({out_ch.status, out_ch.send_revoke, out_ch.send_retry,
                           out_ch.target_client, out_ch.acquire_count});
    end
  end

  // Give up when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lock_directory_revoke_retry_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request beat, with random idle cycles ahead of it, and wait
  // for it to be taken. Called and returns just after a falling edge.
  task automatic send_request(logic [1:0] op, logic [SLOT_W-1:0] slot,
                              logic [CLIENT_W-1:0] cl);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.lock_slot = slot;
    in_ch.client    = cl;
    do @(posedge clk); while (!in_ch.ready);
    book.predict_request(op, slot, cl);
    @(negedge clk);
  endtask

  // Mostly contention on a few hot slots among a few clients, plus scattered noise.
  task automatic send_random_requests(int count);
    int pick;
    logic [1:0] op;
    logic [SLOT_W-1:0] slot;
    logic [CLIENT_W-1:0] cl;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) op = OP_ACQUIRE;
      else if (pick < 82) op = OP_RELEASE;
      else if (pick < 93) op = OP_STAT;
      else op = OP_UNDEFINED;
      slot = ($urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, 3))
                                         : SLOT_W'($urandom_range(0, LOCK_SLOTS - 1));
      cl = ($urandom_range(0, 3) < 3) ? CLIENT_W'($urandom_range(0, 5))
                                       : CLIENT_W'($urandom_range(0, CLIENTS - 1));
      send_request(op, slot, cl);
    end
  endtask

  initial begin
    book = new();
    sender_idle_pct   = 7;
    receiver_idle_pct = 52;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_STAT;
    in_ch.lock_slot   = '0;
    in_ch.client      = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: unknown lock, stat and the undefined code before any acquire.
    send_request(OP_RELEASE, 6'd0, 4'd0);
    send_request(OP_STAT, 6'd63, 4'd15);
    send_request(OP_UNDEFINED, 6'd42, 4'd7);
    // Grant, then the owner itself asks again and receives the revoke.
    send_request(OP_ACQUIRE, 6'd0, 4'd5);
    send_request(OP_ACQUIRE, 6'd0, 4'd5);
    // Further waiters get RETRY but no second revoke.
    send_request(OP_ACQUIRE, 6'd0, 4'd0);
    send_request(OP_ACQUIRE, 6'd0, 4'd15);
    // Release by a client that does not own the lock still frees it.
    send_request(OP_RELEASE, 6'd0, 4'd9);
    send_request(OP_ACQUIRE, 6'd0, 4'd0);
    send_request(OP_RELEASE, 6'd0, 4'd0);
    send_request(OP_ACQUIRE, 6'd0, 4'd15);
    send_request(OP_RELEASE, 6'd0, 4'd15);
    // Release of a known free lock that still has a waiter.
    send_request(OP_RELEASE, 6'd0, 4'd3);
    send_request(OP_ACQUIRE, 6'd0, 4'd5);
    send_request(OP_RELEASE, 6'd0, 4'd5);
    // Top slot and client, and release of a free lock nobody waits on.
    send_request(OP_ACQUIRE, 6'd63, 4'd15);
    send_request(OP_ACQUIRE, 6'd63, 4'd10);
    send_request(OP_RELEASE, 6'd63, 4'd15);
    send_request(OP_ACQUIRE, 6'd63, 4'd10);
    send_request(OP_RELEASE, 6'd63, 4'd10);
    send_request(OP_RELEASE, 6'd63, 4'd10);
    send_request(OP_RELEASE, 6'd42, 4'd1);
    send_request(OP_STAT, 6'd21, 4'd10);

    // Random traffic under three backpressure patterns.
    send_random_requests(RANDOM_REQUESTS / 3);
    sender_idle_pct   = 52;
    receiver_idle_pct = 7;
    send_random_requests(RANDOM_REQUESTS / 3);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_random_requests(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
    in_ch.valid = 1'b0;

    // Drain the owed responses, then watch for stray beats.
    while (book.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.error_count == 0 && book.pending_responses.size() == 0) begin
      $display("lock_directory_revoke_retry_unit: match");
    end else begin
      $display("lock_directory_revoke_retry_unit: mismatch");
    end
    $finish;
  end

endmodule
